[sv/lqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_pkg
// Shared types and constants for the linear queue with search.
// ----------------------------------------------------------------------------
package lqs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CAP_W      = 5;
    localparam int STATUS_W   = 3;
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 3;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // register word index on the configuration port
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_REJ_FULL  = 3'd1,
        ST_REJ_EMPTY = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } t_back_state;

    typedef struct packed {
        t_op                   op;
        logic [DATA_WIDTH-1:0] value;
    } t_cmd;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmdq_head;

endpackage

[sv/lqs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lqs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_front
// Accepts command transactions, decodes the opcode and buffers commands in a
// short queue ahead of the back end.
// ----------------------------------------------------------------------------
module lqs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lqs_pkg::OP_W-1:0]      i_opcode,
    input  logic [lqs_pkg::DATA_WIDTH-1:0] i_data_value,
    input  logic                          i_pop,
    output logic                          o_busy,
    output lqs_pkg::t_cmdq_head           o_head
);

    lqs_pkg::t_cmd                     r_q [lqs_pkg::CMDQ_DEPTH];
    logic [lqs_pkg::CMDQ_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [lqs_pkg::CMDQ_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [lqs_pkg::CMDQ_CNT_W-1:0]    r_count, n_count;
    logic                              push;
    logic                              pop;
    lqs_pkg::t_cmd                     new_cmd;

    assign o_busy = (r_count == lqs_pkg::CMDQ_CNT_W'(lqs_pkg::CMDQ_DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_count != '0);

    always_comb begin
        new_cmd.op    = lqs_pkg::t_op'(i_opcode);
        new_cmd.value = i_data_value;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_cmd;
        end
    end

    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.cmd   = r_q[r_rd_ptr];
    end

endmodule

[sv/lqs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_back
// Executes queued commands against the slot store. Searches walk head..tail,
// one slot read per cycle; a match is held back one step so that the final
// match can carry the last flag.
// ----------------------------------------------------------------------------
module lqs_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lqs_pkg::t_cmdq_head             i_head,
    input  logic [lqs_pkg::CAP_W-1:0]       i_usable,
    output logic                            o_pop,
    output logic                            o_strobe,
    output logic [lqs_pkg::STATUS_W-1:0]    o_status,
    output logic [lqs_pkg::IDX_W-1:0]       o_match_index,
    output logic                            o_is_last,
    output logic                            o_queue_empty,
    output logic                            o_queue_full
);

    lqs_pkg::t_back_state r_state, n_state;

    logic [lqs_pkg::IDX_W-1:0]      r_head, n_head;
    logic [lqs_pkg::IDX_W-1:0]      r_tail, n_tail;
    logic                           r_holds, n_holds;

    logic [lqs_pkg::IDX_W-1:0]      r_addr, n_addr;
    logic                           r_issue_done, n_issue_done;
    logic [lqs_pkg::DATA_WIDTH-1:0] r_key, n_key;
    logic                           r_cmp_valid, n_cmp_valid;
    logic [lqs_pkg::IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                           r_cmp_last, n_cmp_last;
    logic                           r_pend_valid, n_pend_valid;
    logic [lqs_pkg::IDX_W-1:0]      r_pend_idx, n_pend_idx;

    logic                           r_out_valid, n_out_valid;
    lqs_pkg::t_status               r_status, n_status;
    logic [lqs_pkg::IDX_W-1:0]      r_index, n_index;
    logic                           r_is_last, n_is_last;
    logic                           r_empty, n_empty;
    logic                           r_full, n_full;

    logic                           ram_we;
    logic [lqs_pkg::IDX_W-1:0]      ram_waddr;
    logic [lqs_pkg::IDX_W-1:0]      ram_raddr;
    logic [lqs_pkg::DATA_WIDTH-1:0] ram_rdata;
    logic                           full_now;
    logic                           hit;

    lqs_ram #(
        .WIDTH (lqs_pkg::DATA_WIDTH),
        .DEPTH (lqs_pkg::DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_head.cmd.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_pop    = (r_state == lqs_pkg::BK_IDLE) && i_head.valid;
    assign full_now = r_holds &&
                      ((lqs_pkg::CAP_W'(r_tail) + 1'b1) >= i_usable);
    assign hit      = r_cmp_valid && (ram_rdata == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lqs_pkg::BK_IDLE: begin
                if (o_pop && (i_head.cmd.op == lqs_pkg::OP_SEARCH) && r_holds) begin
                    n_state = lqs_pkg::BK_SCAN;
                end
            end
            lqs_pkg::BK_SCAN: begin
                if (r_cmp_valid && r_cmp_last) begin
                    n_state = lqs_pkg::BK_FINISH;
                end
            end
            lqs_pkg::BK_FINISH: begin
                n_state = lqs_pkg::BK_IDLE;
            end
            default: begin
                n_state = lqs_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_holds      = r_holds;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_key        = r_key;
        n_cmp_valid  = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_last   = r_cmp_last;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = 1'b0;
        n_status     = lqs_pkg::ST_DONE;
        n_index      = '0;
        n_is_last    = 1'b1;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_raddr    = r_addr;

        case (r_state)
            lqs_pkg::BK_IDLE: begin
                if (o_pop) begin
                    n_out_valid = 1'b1;
                    case (i_head.cmd.op)
                        lqs_pkg::OP_ENQUEUE: begin
                            if (!r_holds) begin
                                n_head    = '0;
                                n_tail    = '0;
                                n_holds   = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                            end else if (full_now) begin
                                n_status = lqs_pkg::ST_REJ_FULL;
                            end else begin
                                n_tail    = r_tail + 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = r_tail + 1'b1;
                            end
                        end
                        lqs_pkg::OP_DEQUEUE: begin
                            if (!r_holds) begin
                                n_status = lqs_pkg::ST_REJ_EMPTY;
                            end else if (r_head == r_tail) begin
                                n_holds = 1'b0;
                                n_head  = '0;
                                n_tail  = '0;
                            end else begin
                                n_head = r_head + 1'b1;
                            end
                        end
                        lqs_pkg::OP_SEARCH: begin
                            if (!r_holds) begin
                                n_status = lqs_pkg::ST_NOT_FOUND;
                            end else begin
                                // results come from the scan instead
                                n_out_valid  = 1'b0;
                                n_addr       = r_head;
                                n_issue_done = 1'b0;
                                n_key        = i_head.cmd.value;
                                n_pend_valid = 1'b0;
                            end
                        end
                        default: begin
                            n_status = lqs_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lqs_pkg::BK_SCAN: begin
                // read side: one slot per cycle, data returns next cycle
                if (!r_issue_done) begin
                    n_cmp_valid  = 1'b1;
                    n_cmp_idx    = r_addr;
                    n_cmp_last   = (r_addr == r_tail);
                    n_issue_done = (r_addr == r_tail);
                    n_addr       = r_addr + 1'b1;
                end
                // compare side: the previous match is now known not to be last
                if (hit) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_status    = lqs_pkg::ST_FOUND;
                        n_index     = r_pend_idx;
                        n_is_last   = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_idx   = r_cmp_idx;
                end
            end
            lqs_pkg::BK_FINISH: begin
                n_out_valid = 1'b1;
                if (r_pend_valid) begin
                    n_status = lqs_pkg::ST_FOUND;
                    n_index  = r_pend_idx;
                end else begin
                    n_status = lqs_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase

        n_empty = !n_holds;
        n_full  = n_holds && ((lqs_pkg::CAP_W'(n_tail) + 1'b1) >= i_usable);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lqs_pkg::BK_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_holds      <= 1'b0;
            r_issue_done <= 1'b1;
            r_cmp_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_holds      <= n_holds;
            r_issue_done <= n_issue_done;
            r_cmp_valid  <= n_cmp_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_key      <= n_key;
        r_cmp_idx  <= n_cmp_idx;
        r_cmp_last <= n_cmp_last;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_index    <= n_index;
        r_is_last  <= n_is_last;
        r_empty    <= n_empty;
        r_full     <= n_full;
    end

    assign o_strobe      = r_out_valid;
    assign o_status      = r_status;
    assign o_match_index = r_index;
    assign o_is_last     = r_is_last;
    assign o_queue_empty = r_empty;
    assign o_queue_full  = r_full;

endmodule

[sv/linear_queue_with_search.sv]
`timescale 1ns / 1ps
// Results: enqueue, dequeue and searches of an empty queue give one registered result
//   each once the command leaves the command queue; a search gives its results as it
//   scans head to tail, one slot compared per cycle through the slot RAM read port.
// Throughput: one command per cycle for single-result commands; searches are bound
//   by the slot scan. A two-entry command queue lets start be taken during a scan.
// Reset (synchronous, active low) empties the queue and sets capacity to 16.
// ----------------------------------------------------------------------------
// linear_queue_with_search
// Linear array queue with head/tail slots and a value search, with an APB
// configuration register for the usable capacity.
// ----------------------------------------------------------------------------
module linear_queue_with_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lqs_pkg::OP_W-1:0]         i_opcode,
    input  logic signed [lqs_pkg::DATA_WIDTH-1:0] i_data_value,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lqs_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic                             o_strobe,
    output logic [lqs_pkg::STATUS_W-1:0]     o_status,
    output logic [lqs_pkg::IDX_W-1:0]        o_match_index,
    output logic                             o_is_last,
    output logic                             o_queue_empty,
    output logic                             o_queue_full
);

    logic [lqs_pkg::CAP_W-1:0] r_capacity;
    logic [lqs_pkg::CAP_W-1:0] usable;
    logic                      cap_sel;
    lqs_pkg::t_cmdq_head       cmdq_head;
    logic                      cmd_pop;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[lqs_pkg::ADDR_W-1] == lqs_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lqs_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_capacity <= pwdata[lqs_pkg::CAP_W-1:0];
        end
    end

    assign prdata = cap_sel ? {{(32 - lqs_pkg::CAP_W){1'b0}}, r_capacity} : '0;

    // zero acts as one slot, anything above the built depth as the depth
    always_comb begin
        if (r_capacity == '0) begin
            usable = lqs_pkg::CAP_W'(1);
        end else if (r_capacity > lqs_pkg::CAP_W'(lqs_pkg::DEPTH)) begin
            usable = lqs_pkg::CAP_W'(lqs_pkg::DEPTH);
        end else begin
            usable = r_capacity;
        end
    end

    lqs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_opcode     (i_opcode),
        .i_data_value (i_data_value),
        .i_pop        (cmd_pop),
        .o_busy       (busy),
        .o_head       (cmdq_head)
    );

    lqs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (cmdq_head),
        .i_usable      (usable),
        .o_pop         (cmd_pop),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_match_index (o_match_index),
        .o_is_last     (o_is_last),
        .o_queue_empty (o_queue_empty),
        .o_queue_full  (o_queue_full)
    );

endmodule

[sv/lqs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_checker
// Port-level checks on the result transactions of the queue.
// ----------------------------------------------------------------------------
module lqs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_strobe,
    input logic [lqs_pkg::STATUS_W-1:0] o_status,
    input logic [lqs_pkg::IDX_W-1:0]    o_match_index,
    input logic                         o_is_last,
    input logic                         o_queue_empty,
    input logic                         o_queue_full
);

    // no result straight out of reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    a_empty_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_queue_empty |-> !o_queue_full)
        else $error("queue reported both empty and full");

    a_found_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == lqs_pkg::ST_FOUND) |-> !o_queue_empty)
        else $error("match reported on an empty queue");

    // only search matches can be followed by further results
    a_single_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != lqs_pkg::ST_FOUND) |-> o_is_last &&
        (o_match_index == '0))
        else $error("non-match result not last or with an index");

endmodule

bind linear_queue_with_search lqs_checker u_lqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_strobe      (o_strobe),
    .o_status      (o_status),
    .o_match_index (o_match_index),
    .o_is_last     (o_is_last),
    .o_queue_empty (o_queue_empty),
    .o_queue_full  (o_queue_full)
);

[verif/lqs_queue_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_queue_checker
// Watches the command, result and register ports of the linear queue with
// search, keeps its own copy of the queue, predicts every result and compares
// each strobed result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lqs_queue_checker
    import lqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [DATA_WIDTH-1:0] i_data_value,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_W-1:0]     i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic [31:0]           i_prdata,
    input  logic                  i_pready,
    input  logic                  i_strobe,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [IDX_W-1:0]      i_match_index,
    input  logic                  i_is_last,
    input  logic                  i_queue_empty,
    input  logic                  i_queue_full,
    output int                    o_pending,
    output int                    o_errors
);

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic             last;
        logic             empty;
        logic             full;
    } t_queue_result;

    t_queue_result         expected_results[$];
    t_queue_result         oldest;
    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
    int unsigned           head_ptr;
    int unsigned           tail_ptr;
    bit                    occupied;
    logic [CAP_W-1:0]      capacity;
    int                    errors;

    function automatic int unsigned slots_allowed();
        int unsigned c;
        c = capacity;
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    // full as soon as the tail reaches the last usable slot, even past it
    function automatic bit queue_is_full();
        return occupied && (tail_ptr + 1 >= slots_allowed());
    endfunction

    function automatic void push_result(t_status st, int unsigned idx, bit last);
        t_queue_result r;
        r.status = st;
        r.index  = IDX_W'(idx);
        r.last   = last;
        r.empty  = !occupied;
        r.full   = queue_is_full();
        expected_results.push_back(r);
    endfunction

    function automatic void predict_queue_op(t_op op, logic [DATA_WIDTH-1:0] value);
        int unsigned hits[$];
        case (op)
            OP_ENQUEUE: begin
                if (!occupied) begin
                    head_ptr    = 0;
                    tail_ptr    = 0;
                    slot_mem[0] = value;
                    occupied    = 1'b1;
                    push_result(ST_DONE, 0, 1'b1);
                end else if (queue_is_full()) begin
                    push_result(ST_REJ_FULL, 0, 1'b1);
                end else begin
                    tail_ptr           = tail_ptr + 1;
                    slot_mem[tail_ptr] = value;
                    push_result(ST_DONE, 0, 1'b1);
                end
            end
            OP_DEQUEUE: begin
                if (!occupied) begin
                    push_result(ST_REJ_EMPTY, 0, 1'b1);
                end else if (head_ptr == tail_ptr) begin
                    occupied = 1'b0;
                    head_ptr = 0;
                    tail_ptr = 0;
                    push_result(ST_DONE, 0, 1'b1);
                end else begin
                    head_ptr = head_ptr + 1;
                    push_result(ST_DONE, 0, 1'b1);
                end
            end
            OP_SEARCH: begin
                if (occupied) begin
                    for (int unsigned i = head_ptr; i <= tail_ptr; i++) begin
                        if (slot_mem[i] == value) hits.push_back(i);
                    end
                end
                if (hits.size() == 0) begin
                    push_result(ST_NOT_FOUND, 0, 1'b1);
                end else begin
                    foreach (hits[k]) push_result(ST_FOUND, hits[k], k == hits.size() - 1);
                end
            end
            default: push_result(ST_DONE, 0, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            head_ptr = 0;
            tail_ptr = 0;
            occupied = 1'b0;
            capacity = CAPACITY_RESET;
        end else begin
            // results first: nothing accepted at this edge can already be out
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", 32'hffff_ffff, 32'(i_status));
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_status !== oldest.status)
                        report_mismatch("status", 32'(oldest.status), 32'(i_status));
                    if (i_match_index !== oldest.index)
                        report_mismatch("match_index", 32'(oldest.index), 32'(i_match_index));
                    if (i_is_last !== oldest.last)
                        report_mismatch("is_last", 32'(oldest.last), 32'(i_is_last));
                    if (i_queue_empty !== oldest.empty)
                        report_mismatch("queue_empty", 32'(oldest.empty), 32'(i_queue_empty));
                    if (i_queue_full !== oldest.full)
                        report_mismatch("queue_full", 32'(oldest.full), 32'(i_queue_full));
                end
            end
            if (i_start && !i_busy) predict_queue_op(t_op'(i_opcode), i_data_value);
            if (i_psel && i_penable && i_pready && (i_paddr[ADDR_W-1:2] == REG_CAPACITY)) begin
                if (i_pwrite) begin
                    capacity = i_pwdata[CAP_W-1:0];
                end else if (i_prdata !== 32'(capacity)) begin
                    report_mismatch("capacity read", 32'(capacity), i_prdata);
                end
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= errors;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the linear queue with search through directed corner cases and
// random phases of enqueue, dequeue and search transactions under changing
// capacity settings; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import lqs_pkg::*;

    localparam int ITEM_TARGET = 450;
    localparam int STALL_LIMIT = 1000;
    localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(REG_CAPACITY) << 2;

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic [OP_W-1:0]       opcode       = OP_ENQUEUE;
    logic [DATA_WIDTH-1:0] data_value   = '0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_W-1:0]     paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic                  busy;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  o_strobe;
    logic [STATUS_W-1:0]   o_status;
    logic [IDX_W-1:0]      o_match_index;
    logic                  o_is_last;
    logic                  o_queue_empty;
    logic                  o_queue_full;

    int pending;
    int errors;
    int items_sent;
    int stall_cycles;

    linear_queue_with_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (opcode),
        .i_data_value  (data_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_match_index (o_match_index),
        .o_is_last     (o_is_last),
        .o_queue_empty (o_queue_empty),
        .o_queue_full  (o_queue_full)
    );

    lqs_queue_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_opcode      (opcode),
        .i_data_value  (data_value),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_match_index (o_match_index),
        .i_is_last     (o_is_last),
        .i_queue_empty (o_queue_empty),
        .i_queue_full  (o_queue_full),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycles in which no transaction of any kind completes
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // start stays high across back-to-back transactions
    task automatic issue_op(t_op op, logic [DATA_WIDTH-1:0] value, int gap, bit hold);
        if (gap > 0 || hold) start <= 1'b0;
        repeat (gap) @(posedge i_clk);
        if (hold) begin
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        data_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic reg_access(bit wr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [31:0] value);
        reg_access(1'b1, value);
        reg_access(1'b0, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int draw_gap(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 18);
            default: return ($urandom_range(0, 7) == 0) ? 18 : 0;
        endcase
    endfunction

    initial begin
        logic [DATA_WIDTH-1:0] pool [3];
        logic [31:0]           cap_word;
        int                    phase_len;
        int                    mode;
        int                    enq_pct;
        int                    r;
        t_op                   op;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, unused opcode, field extremes, duplicate matches
        issue_op(OP_SEARCH, '0, 0, 1'b0);
        issue_op(OP_DEQUEUE, $urandom, 1, 1'b0);
        issue_op(OP_UNUSED, $urandom, 0, 1'b0);
        issue_op(OP_ENQUEUE, 32'h8000_0000, 0, 1'b0);
        issue_op(OP_ENQUEUE, 32'h7fff_ffff, 2, 1'b0);
        issue_op(OP_ENQUEUE, 32'h0000_0000, 0, 1'b0);
        issue_op(OP_ENQUEUE, 32'hffff_ffff, 0, 1'b0);
        issue_op(OP_ENQUEUE, 32'hffff_ffff, 3, 1'b0);
        issue_op(OP_SEARCH, 32'hffff_ffff, 0, 1'b0);
        issue_op(OP_SEARCH, 32'h8000_0000, 0, 1'b0);
        issue_op(OP_SEARCH, 32'h1234_5678, 1, 1'b0);
        issue_op(OP_DEQUEUE, '0, 0, 1'b0);
        issue_op(OP_SEARCH, 32'h8000_0000, 0, 1'b0);
        issue_op(OP_UNUSED, 32'hffff_ffff, 0, 1'b0);
        repeat (4) issue_op(OP_DEQUEUE, $urandom, 0, 1'b0);
        issue_op(OP_DEQUEUE, '0, 0, 1'b0);
        wait_drained();

        // single slot: full after one transaction
        set_capacity(32'd1);
        issue_op(OP_ENQUEUE, 32'd5, 0, 1'b0);
        issue_op(OP_ENQUEUE, 32'd6, 0, 1'b0);
        issue_op(OP_SEARCH, 32'd5, 0, 1'b0);
        issue_op(OP_DEQUEUE, '0, 0, 1'b0);
        wait_drained();

        // capacity lowered below the tail
        set_capacity(32'd16);
        for (int i = 0; i < 6; i++) issue_op(OP_ENQUEUE, 32'(100 + i), 0, 1'b0);
        wait_drained();
        set_capacity(32'd2);
        issue_op(OP_ENQUEUE, 32'd7, 0, 1'b0);
        issue_op(OP_SEARCH, 32'd105, 0, 1'b0);
        issue_op(OP_DEQUEUE, '0, 0, 1'b0);
        wait_drained();
        set_capacity(32'd0);
        issue_op(OP_ENQUEUE, 32'd8, 0, 1'b0);
        issue_op(OP_SEARCH, 32'd103, 0, 1'b0);
        wait_drained();
        set_capacity(32'hffff_ffff);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_drained();
                r = $urandom_range(0, 9);
                case (r)
                    0:       cap_word = 0;
                    1:       cap_word = 1;
                    2:       cap_word = 2;
                    3:       cap_word = 16;
                    4:       cap_word = 31;
                    default: cap_word = $urandom_range(1, 16);
                endcase
                if ($urandom_range(0, 3) == 0) cap_word = ($urandom & ~32'h1f) | cap_word;
                set_capacity(cap_word);
            end
            foreach (pool[k]) pool[k] = $urandom;
            phase_len = $urandom_range(10, 50);
            mode      = $urandom_range(0, 2);
            r         = $urandom_range(0, 2);
            enq_pct   = (r == 0) ? 30 : (r == 1) ? 50 : 70;
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < enq_pct)
                    op = OP_ENQUEUE;
                else if (r < enq_pct + (97 - enq_pct) / 2)
                    op = OP_DEQUEUE;
                else if (r < 97)
                    op = OP_SEARCH;
                else
                    op = OP_UNUSED;
                issue_op(op,
                         ($urandom_range(0, 6) == 0) ? $urandom : pool[$urandom_range(0, 2)],
                         draw_gap(mode), $urandom_range(0, 24) == 0);
            end
        end

        wait_drained();
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
